FILE: sv/bha_pkg.sv
// Shared types and constants for the bitmap handle allocator.
// Used by the top level, the summary search and the port checker; no dependencies.
package bha_pkg;

	localparam int HANDLE_W   = 10;
	localparam int FIELD_SPAN = 1024;
	// byte address into the in-use map; the 10-bit handle field caps it at 128 bytes
	localparam int MAP_AW     = 7;
	localparam int BIT_W      = 3;

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic {
		ST_OK   = 1'b0,
		ST_FAIL = 1'b1
	} status_t;

	// write-back of one map byte into the summary
	typedef struct packed {
		logic              en;
		logic [MAP_AW-1:0] addr;
		logic              full;
	} sum_upd_t;

	// lowest map byte that still holds a free handle
	typedef struct packed {
		logic              found;
		logic [MAP_AW-1:0] addr;
	} sum_pick_t;

endpackage

FILE: sv/bitmap_handle_allocator.sv
// Top level of the bitmap handle allocator: byte-wide in-use map memory,
// read-modify-write sequencer and result register. Depends on bha_pkg, bha_summary.
//
//  channel | dir | tdata                    | tuser
//  s_*     | in  | [9:0] handle_index       | [0] operation
//  m_*     | out | [9:0] granted_handle     | [0] status
//
// From acceptance to a valid result, the accepting edge registers the first summary level,
// the read state finishes the search and reads the map, and the write-back state modifies
// and writes the byte back and loads the result register; s_tready then returns, so a
// new item is taken only once the last has left the write-back stage.
// The single map memory port keeps one item in flight at a time.
// A result that is not taken holds the write-back stage until m_tready.
// After reset every handle is free; no clearing pass is needed.
module bitmap_handle_allocator #(
	parameter int HANDLE_COUNT   = 1024,
	parameter int RESERVED_COUNT = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [9:0] handle_index
	input  logic [0:0]  s_tuser,   // [0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [9:0] granted_handle
	output logic [0:0]  m_tuser    // [0] status
);

	localparam int LIMIT     = (HANDLE_COUNT < bha_pkg::FIELD_SPAN) ?
	                           HANDLE_COUNT : bha_pkg::FIELD_SPAN;
	localparam int NUM_BYTES = (LIMIT + 7) / 8;
	localparam int AW        = $clog2(NUM_BYTES);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RD   = 3'b010,
		S_WB   = 3'b100
	} state_t;

	state_t                           state_q;
	bha_pkg::op_t                     op_q;
	logic [bha_pkg::HANDLE_W-1:0]     hidx_q;
	logic [bha_pkg::MAP_AW-1:0]       addr_q;
	logic                             ok_q;
	logic [7:0]                       rdata_q;
	logic                             rvalid_q;
	logic [7:0]                       mem [NUM_BYTES];
	logic [NUM_BYTES-1:0]             valid_q;
	logic                             out_valid_q;
	bha_pkg::status_t                 out_status_q;
	logic [bha_pkg::HANDLE_W-1:0]     out_handle_q;

	logic                             accept;
	bha_pkg::sum_pick_t               pick;
	bha_pkg::sum_upd_t                upd;
	logic                             rd_ok;
	logic [bha_pkg::MAP_AW-1:0]       rd_addr;
	logic                             rd_en;
	logic [7:0]                       smask;
	logic [7:0]                       raw;
	logic [7:0]                       eff;
	logic [bha_pkg::BIT_W-1:0]        bitpos;
	logic                             any_zero;
	logic [7:0]                       onehot;
	logic [7:0]                       newraw;
	logic                             succ;
	logic                             fire;
	logic                             wr_en;

	// bits of a map byte that are never handed out: reserved or past the pool
	function automatic logic [7:0] static_mask(input logic [bha_pkg::MAP_AW-1:0] b);
		int          h;
		logic [7:0]  m;
		for (int i = 0; i < 8; i++) begin
			h    = int'(b) * 8 + i;
			m[i] = (h < RESERVED_COUNT) || (h >= LIMIT);
		end
		return m;
	endfunction

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	bha_summary #(
		.NUM_BYTES      (NUM_BYTES),
		.RESERVED_COUNT (RESERVED_COUNT)
	) u_summary (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.upd    (upd),
		.pick   (pick)
	);

	// read stage: pick the byte to touch
	always_comb begin
		if (op_q == bha_pkg::OP_ALLOC) begin
			rd_ok   = pick.found;
			rd_addr = pick.addr;
		end else begin
			rd_ok   = (hidx_q >= bha_pkg::HANDLE_W'(RESERVED_COUNT)) &&
			          ({1'b0, hidx_q} < 11'(LIMIT));
			rd_addr = hidx_q[bha_pkg::HANDLE_W-1:bha_pkg::BIT_W];
		end
	end

	assign rd_en = (state_q == S_RD) && rd_ok;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q  <= mem[rd_addr[AW-1:0]];
			rvalid_q <= valid_q[rd_addr[AW-1:0]];
		end
	end

	// write-back stage: modify the byte
	assign smask = static_mask(addr_q);
	assign raw   = rvalid_q ? rdata_q : 8'h00;
	assign eff   = raw | smask;

	always_comb begin
		bitpos   = '0;
		any_zero = 1'b0;
		for (int i = 7; i >= 0; i--) begin
			if (!eff[i]) begin
				bitpos   = bha_pkg::BIT_W'(i);
				any_zero = 1'b1;
			end
		end
		if (op_q == bha_pkg::OP_RELEASE) begin
			bitpos = hidx_q[bha_pkg::BIT_W-1:0];
		end
	end

	assign onehot = 8'h01 << bitpos;

	always_comb begin
		if (op_q == bha_pkg::OP_ALLOC) begin
			succ   = ok_q && any_zero;
			newraw = raw | onehot;
		end else begin
			succ   = ok_q && raw[bitpos];
			newraw = raw & ~onehot;
		end
	end

	assign fire  = (state_q == S_WB) && (!out_valid_q || m_tready);
	assign wr_en = fire && succ;

	assign upd.en   = wr_en;
	assign upd.addr = addr_q;
	assign upd.full = &(newraw | smask);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_q[AW-1:0]] <= newraw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[addr_q[AW-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_WB;
				end
				S_WB: begin
					if (fire) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= bha_pkg::op_t'(s_tuser[0]);
			hidx_q <= s_tdata[bha_pkg::HANDLE_W-1:0];
		end
		if (state_q == S_RD) begin
			addr_q <= rd_addr;
			ok_q   <= rd_ok;
		end
	end

	// result register; hold while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_status_q <= succ ? bha_pkg::ST_OK : bha_pkg::ST_FAIL;
			out_handle_q <= (succ && op_q == bha_pkg::OP_ALLOC) ? {addr_q, bitpos} : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_handle_q};
	assign m_tuser  = out_status_q;

endmodule

FILE: sv/bha_summary.sv
// Per-byte full flags of the in-use map and a two-level search for the lowest
// byte with a free handle. Depends on bha_pkg.
module bha_summary #(
	parameter int NUM_BYTES      = 128,
	parameter int RESERVED_COUNT = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  bha_pkg::sum_upd_t   upd,
	output bha_pkg::sum_pick_t  pick
);

	localparam int NG = (NUM_BYTES + 7) / 8;
	localparam int AW = $clog2(NUM_BYTES);

	logic [NUM_BYTES-1:0] full_q;
	logic [NG*8-1:0]      free_bytes;
	logic [NG-1:0]        grp_any;
	logic [2:0]           grp_low [NG];
	logic [NG-1:0]        grp_any_s1;
	logic [2:0]           grp_low_s1 [NG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
		end else if (upd.en) begin
			full_q[upd.addr[AW-1:0]] <= upd.full;
		end
	end

	// a byte made only of reserved handles never has room
	always_comb begin
		free_bytes = '0;
		for (int b = 0; b < NUM_BYTES; b++) begin
			free_bytes[b] = !full_q[b] && !((b + 1) * 8 <= RESERVED_COUNT);
		end
	end

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_any[g] = |free_bytes[g*8 +: 8];
			grp_low[g] = 3'd0;
			for (int i = 7; i >= 0; i--) begin
				if (free_bytes[g*8 + i]) begin
					grp_low[g] = 3'(i);
				end
			end
		end
	end

	// first level of the search, registered when an item is taken
	always_ff @(posedge clk) begin
		if (start) begin
			grp_any_s1 <= grp_any;
			grp_low_s1 <= grp_low;
		end
	end

	always_comb begin
		pick.found = 1'b0;
		pick.addr  = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (grp_any_s1[g]) begin
				pick.found = 1'b1;
				pick.addr  = bha_pkg::MAP_AW'(g * 8) + bha_pkg::MAP_AW'(grp_low_s1[g]);
			end
		end
	end

endmodule

FILE: sv/bha_checker.sv
// Port-level checks for the bitmap handle allocator, bound to the top level.
// Depends on bha_pkg and on bitmap_handle_allocator.
module bha_checker #(
	parameter int RESERVED_COUNT = 3
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one item in flight
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while busy");

	// a fresh result must follow an accepted item
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 3))
		else $error("result without a matching item");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[0] == bha_pkg::ST_FAIL) |-> m_tdata == 16'd0)
		else $error("failed request carries a handle");

	a_no_reserved: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[0] == bha_pkg::ST_OK) && (m_tdata != 16'd0)
		|-> m_tdata >= 16'(RESERVED_COUNT))
		else $error("reserved handle granted");

endmodule

bind bitmap_handle_allocator bha_checker #(
	.RESERVED_COUNT (RESERVED_COUNT)
) u_bha_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

FILE: sim/bitmap_handle_allocator_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for bitmap_handle_allocator: directed and random allocate/release
// traffic with random gaps and output stalls, every reply checked against a bit-level
// map. Depends on bha_pkg.
module bitmap_handle_allocator_tb;

	localparam int HANDLE_TOTAL     = 1024;
	localparam int RESERVED_HANDLES = 3;
	localparam int SCAN_END         = (HANDLE_TOTAL < bha_pkg::FIELD_SPAN) ?
	                                  HANDLE_TOTAL : bha_pkg::FIELD_SPAN;
	localparam int IDLE_LIMIT       = 2000;
	localparam int FILL_ITEMS       = 1150;
	localparam int CHURN_ITEMS      = 350;

	typedef struct packed {
		bha_pkg::op_t                 op;
		logic [bha_pkg::HANDLE_W-1:0] idx;
	} handle_request_t;

	typedef struct packed {
		bha_pkg::status_t             status;
		logic [bha_pkg::HANDLE_W-1:0] granted;
	} handle_reply_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [9:0] handle_index
	logic [0:0]  s_tuser;   // [0] operation
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [9:0] granted_handle
	logic [0:0]  m_tuser;   // [0] status

	handle_request_t pending_requests[$];
	handle_reply_t   expected_replies[$];
	bit              handle_busy[0:HANDLE_TOTAL-1];

	int unsigned total_requests;
	int unsigned sent_count;
	int unsigned taken_count;
	int unsigned idle_cycles;
	int unsigned error_count;
	bit          timed_out;

	int unsigned n_grants;
	int unsigned n_exhausted;
	int unsigned n_freed;
	int unsigned n_refused;

	int unsigned send_gap;
	int unsigned send_quiet;
	int unsigned stall_left;
	int unsigned stall_quiet;

	bitmap_handle_allocator #(
		.HANDLE_COUNT  (HANDLE_TOTAL),
		.RESERVED_COUNT(RESERVED_HANDLES)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// grant lowest free handle above the reserved range, or free one handle
	task automatic allocate_or_release(input handle_request_t req, output handle_reply_t rep);
		int  h;
		bit  found;
		rep.status  = bha_pkg::ST_FAIL;
		rep.granted = '0;
		found       = 1'b0;
		if (req.op == bha_pkg::OP_ALLOC) begin
			for (h = RESERVED_HANDLES; h < SCAN_END && !found; h++) begin
				if (!handle_busy[h]) begin
					handle_busy[h] = 1'b1;
					rep.status     = bha_pkg::ST_OK;
					rep.granted    = h[bha_pkg::HANDLE_W-1:0];
					found          = 1'b1;
				end
			end
		end else if (req.idx >= RESERVED_HANDLES && req.idx < SCAN_END &&
		             handle_busy[req.idx]) begin
			handle_busy[req.idx] = 1'b0;
			rep.status           = bha_pkg::ST_OK;
		end
	endtask

	// driver: one item on the bus at a time, next item only once the last was taken
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else if (taken_count == sent_count) begin
			if (send_quiet > 0)
				send_quiet--;
			else if ($urandom_range(0, 99) < 3)
				send_quiet = $urandom_range(20, 60);
			if (send_gap > 0) begin
				s_tvalid <= 1'b0;
				send_gap--;
			end else if (pending_requests.size() > 0) begin
				s_tdata  <= {6'b0, pending_requests[0].idx};
				s_tuser  <= pending_requests[0].op;
				s_tvalid <= 1'b1;
				void'(pending_requests.pop_front());
				sent_count++;
				send_gap = (send_quiet > 0) ? 0 : pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// output backpressure
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (stall_quiet > 0)
				stall_quiet--;
			else if ($urandom_range(0, 99) < 3)
				stall_quiet = $urandom_range(20, 60);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (stall_quiet == 0 && $urandom_range(0, 99) < 25)
					stall_left = pick_gap();
			end
		end
	end

	// monitor: predict on input accept, check on output accept
	always @(posedge clk) begin
		handle_request_t req;
		handle_reply_t   rep;
		handle_reply_t   exp_rep;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				req.op  = bha_pkg::op_t'(s_tuser[0]);
				req.idx = s_tdata[bha_pkg::HANDLE_W-1:0];
				allocate_or_release(req, rep);
				expected_replies.push_back(rep);
				taken_count++;
				if (req.op == bha_pkg::OP_ALLOC) begin
					if (rep.status == bha_pkg::ST_OK) n_grants++;
					else n_exhausted++;
				end else begin
					if (rep.status == bha_pkg::ST_OK) n_freed++;
					else n_refused++;
				end
			end
			if (m_tvalid && m_tready) begin
				if (expected_replies.size() == 0) begin
					$display("%0t: reply with nothing outstanding: status %0d handle %0d",
						$time, m_tuser[0], m_tdata[bha_pkg::HANDLE_W-1:0]);
					error_count++;
				end else begin
					exp_rep = expected_replies.pop_front();
					if (bha_pkg::status_t'(m_tuser[0]) !== exp_rep.status) begin
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, exp_rep.status, m_tuser[0]);
						error_count++;
					end
					if (m_tdata[bha_pkg::HANDLE_W-1:0] !== exp_rep.granted) begin
						$display("%0t: granted_handle mismatch: expected %0d, actual %0d",
							$time, exp_rep.granted, m_tdata[bha_pkg::HANDLE_W-1:0]);
						error_count++;
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else if (!timed_out && ++idle_cycles >= IDLE_LIMIT)
				timed_out = 1'b1;
		end
	end

	task automatic queue_request(input bha_pkg::op_t op, input int unsigned idx);
		handle_request_t req;
		req.op  = op;
		req.idx = idx[bha_pkg::HANDLE_W-1:0];
		pending_requests.push_back(req);
	endtask

	initial begin
		int unsigned n_alloc;
		int unsigned top;
		int unsigned late;
		arst_n = 1'b0;

		// reserved handles, free handles, field extremes, reuse of a freed handle
		queue_request(bha_pkg::OP_RELEASE, 0);
		queue_request(bha_pkg::OP_RELEASE, 1);
		queue_request(bha_pkg::OP_RELEASE, 2);
		queue_request(bha_pkg::OP_RELEASE, 1023);
		queue_request(bha_pkg::OP_RELEASE, 3);
		queue_request(bha_pkg::OP_ALLOC, 1023);
		queue_request(bha_pkg::OP_ALLOC, 0);
		queue_request(bha_pkg::OP_ALLOC, 682);
		queue_request(bha_pkg::OP_RELEASE, 4);
		queue_request(bha_pkg::OP_RELEASE, 4);
		queue_request(bha_pkg::OP_ALLOC, 341);
		queue_request(bha_pkg::OP_ALLOC, 0);
		queue_request(bha_pkg::OP_RELEASE, 3);
		queue_request(bha_pkg::OP_RELEASE, 5);
		queue_request(bha_pkg::OP_ALLOC, 1023);
		queue_request(bha_pkg::OP_ALLOC, 0);
		queue_request(bha_pkg::OP_RELEASE, 2);
		queue_request(bha_pkg::OP_RELEASE, 7);

		// fill until the pool runs dry; releases aim at the low, mostly busy range
		n_alloc = 6;
		for (int i = 0; i < FILL_ITEMS; i++) begin
			if ($urandom_range(0, 99) < 97) begin
				queue_request(bha_pkg::OP_ALLOC, $urandom_range(0, 1023));
				n_alloc++;
			end else begin
				top = (n_alloc + 8 > 1023) ? 1023 : n_alloc + 8;
				queue_request(bha_pkg::OP_RELEASE, $urandom_range(0, top));
			end
		end
		// churn on a nearly full map: holes anywhere, refilled lowest first
		for (int i = 0; i < CHURN_ITEMS; i++) begin
			if ($urandom_range(0, 1) == 0)
				queue_request(bha_pkg::OP_ALLOC, $urandom_range(0, 1023));
			else
				queue_request(bha_pkg::OP_RELEASE, $urandom_range(0, 1023));
		end
		total_requests = pending_requests.size();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (!timed_out && !(taken_count == total_requests && expected_replies.size() == 0))
			@(posedge clk);

		if (timed_out) begin
			$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
			$display("== FAIL ==");
		end else begin
			repeat (20) @(posedge clk);
			late = expected_replies.size();
			if (late != 0)
				$display("%0t: %0d replies never arrived", $time, late);
			$display("Ran %0d requests: %0d grants, %0d allocates on a full pool,",
				total_requests, n_grants, n_exhausted);
			$display("%0d handles freed, %0d releases refused; %0d mismatches",
				n_freed, n_refused, error_count);
			if (error_count == 0 && late == 0)
				$display("== PASS ==");
			else
				$display("== FAIL ==");
		end
		$finish;
	end

endmodule
